// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the camera follow block
// Clocked on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sfc_pkg.sv =====
// ---------------------------------------------------------------------------
// sfc_pkg
// Types, constants and helpers shared by the spring follow camera modules.
// ---------------------------------------------------------------------------
package sfc_pkg;

	localparam int IN_W  = 160;
	localparam int OUT_W = 144;

	// configuration register indexes
	localparam logic [1:0] REG_HDIST  = 2'd0;
	localparam logic [1:0] REG_VDIST  = 2'd1;
	localparam logic [1:0] REG_TDIST  = 2'd2;
	localparam logic [1:0] REG_SPRING = 2'd3;

	localparam logic [15:0] HDIST_RST  = 16'd300;
	localparam logic [15:0] VDIST_RST  = 16'd300;
	localparam logic [15:0] TDIST_RST  = 16'd100;
	localparam logic [15:0] SPRING_RST = 16'd16384;

	// quotient bits of one look component
	localparam logic [3:0] DIV_STEPS = 4'd15;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_HF,
		OP_IDEAL,
		OP_C_LATCH,
		OP_SNAP,
		OP_MUL_KD,
		OP_MUL_CV,
		OP_ACC,
		OP_MUL_AH,
		OP_MUL_AL,
		OP_VEL,
		OP_MUL_VD,
		OP_POS,
		OP_MUL_TF,
		OP_DIFF,
		OP_LOOK_ZERO,
		OP_NORM,
		OP_MUL_SQ,
		OP_SUM,
		OP_LEN_START,
		OP_LEN_LATCH,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_LOOK,
		OP_PUB
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic snap;
		logic sqrt_busy;
		logic vec_zero;
		logic norm_ok;
		logic div_done;
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_HF_MUL,
		S_HF_SAT,
		S_C_WAIT,
		S_SNAP,
		S_KD,
		S_CV,
		S_ACC,
		S_AH,
		S_AL,
		S_VEL,
		S_VD,
		S_POS,
		S_TF,
		S_DIFF,
		S_ZCHK,
		S_NORM,
		S_SQ,
		S_SUM,
		S_LEN_START,
		S_LEN_WAIT,
		S_DIV_START,
		S_DIV_STEP,
		S_PUB
	} state_t;

	// clamp a wide signed value to 32 bits signed
	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (x < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ===== src/spring_follow_camera_step.sv =====
// ---------------------------------------------------------------------------
// spring_follow_camera_step
// Spring follow camera: one camera position and look direction per frame.
// ---------------------------------------------------------------------------
//  port group  dir  word contents
//  s_axis      in   tdata: owner pos x,y,z, forward x,y,z, frame time; tuser: snap
//  m_axis      out  tdata: camera pos x,y,z, look x,y,z
//  cfg         in   write enable, register index, 16-bit value
//
// One item at a time; the time an item takes is set by the two 32-step
// passes of the square root unit, the spring update (skipped on snap),
// the normalising shift (one bit a cycle) and three divides; a zero look
// vector skips the shift, the second root pass and the divides. arst_n
// clears the camera state and config to their defaults. A finished word
// sits in the output register; the next item is accepted meanwhile and
// only waits at its own hand-over.
// ---------------------------------------------------------------------------
module spring_follow_camera_step
	import sfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// owner_pos_x, owner_pos_y, owner_pos_z, forward_x, forward_y, forward_z, frame_time
	input  logic [IN_W-1:0]   s_axis_tdata,
	// snap
	input  logic              s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// cam_pos_x, cam_pos_y, cam_pos_z, look_x, look_y, look_z
	output logic [OUT_W-1:0]  m_axis_tdata,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [15:0]       cfg_data
);

	cmd_t    cmd;
	status_t status;

	sfc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	sfc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (s_axis_tdata),
		.in_snap (s_axis_tuser),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.status  (status),
		.out_data(m_axis_tdata)
	);

endmodule

// ===== src/sfc_isqrt.sv =====
// ---------------------------------------------------------------------------
// sfc_isqrt
// Iterative integer square root of a 64-bit value, one result bit a cycle.
// ---------------------------------------------------------------------------
module sfc_isqrt
	import sfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	output logic        busy,
	output logic [31:0] root
);

	logic [63:0] num_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// control: runs until the probe bit has shifted out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[1:0] != 2'd0) begin
			busy_q <= 1'b0;
		end
	end

	// digit recurrence
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (num_q >= trial) begin
				num_q <= num_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[31:0];

endmodule

// ===== src/sfc_dp.sv =====
// ---------------------------------------------------------------------------
// sfc_dp
// Datapath: config registers, camera state, shared multiplier, square root,
// normalising shifter, divider and the output word register.
// ---------------------------------------------------------------------------
module sfc_dp
	import sfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IN_W-1:0]  in_data,
	input  logic             in_snap,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [15:0]      cfg_data,
	output status_t          status,
	output logic [OUT_W-1:0] out_data
);

	logic [15:0] hdist_q, vdist_q, tdist_q, kspr_q;

	logic signed [31:0] owner_q [3];
	logic signed [15:0] fwd_q   [3];
	logic [15:0]        dt_q;
	logic               snap_q;

	logic signed [31:0] ideal_q [3];
	logic signed [31:0] pos_q   [3];
	logic signed [31:0] vel_q   [3];
	logic [12:0]        damp_q;

	logic signed [65:0] prod_q, t1_q;
	logic signed [47:0] acc_q;

	logic [35:0] mag_q [3];
	logic        neg_q [3];
	logic [63:0] sum_q;
	logic [31:0] len_q;

	logic [32:0] rem_q;
	logic [14:0] quo_q;
	logic [3:0]  div_cnt_q;

	logic signed [15:0] look_q [3];
	logic [OUT_W-1:0]   out_q;

	logic [1:0]         ax;
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [33:0] diff34;
	logic signed [31:0] acc_hi;
	logic signed [63:0] vterm, ideal_w, vel_w, pos_w, dvec_w, dmag_w;
	logic signed [65:0] acc_w;
	logic [35:0]        mmax;
	logic               sq_start;
	logic [63:0]        sq_num;
	logic               sq_busy;
	logic [31:0]        sq_root;
	logic               div_ge;
	logic [32:0]        div_sub;

	assign ax = cmd.axis;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdist_q <= HDIST_RST;
			vdist_q <= VDIST_RST;
			tdist_q <= TDIST_RST;
			kspr_q  <= SPRING_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HDIST:  hdist_q <= cfg_data;
				REG_VDIST:  vdist_q <= cfg_data;
				REG_TDIST:  tdist_q <= cfg_data;
				REG_SPRING: kspr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// multiplier operand select
	assign diff34 = 34'(ideal_q[ax]) - 34'(pos_q[ax]);
	assign acc_hi = acc_q[47:16];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_HF: begin
				mul_a = {18'd0, hdist_q};
				mul_b = 32'(fwd_q[ax]);
			end
			OP_MUL_TF: begin
				mul_a = {18'd0, tdist_q};
				mul_b = 32'(fwd_q[ax]);
			end
			OP_MUL_KD: begin
				mul_a = diff34;
				mul_b = {16'd0, kspr_q};
			end
			OP_MUL_CV: begin
				mul_a = 34'(vel_q[ax]);
				mul_b = {19'd0, damp_q};
			end
			OP_MUL_AH: begin
				mul_a = 34'(acc_hi);
				mul_b = {16'd0, dt_q};
			end
			OP_MUL_AL: begin
				mul_a = {18'd0, acc_q[15:0]};
				mul_b = {16'd0, dt_q};
			end
			OP_MUL_VD: begin
				mul_a = 34'(vel_q[ax]);
				mul_b = {16'd0, dt_q};
			end
			OP_MUL_SQ: begin
				mul_a = {4'd0, mag_q[ax][29:0]};
				mul_b = {2'd0, mag_q[ax][29:0]};
			end
			default: ;
		endcase
	end

	// wide adds feeding the saturating writes
	assign vterm   = (ax == 2'd1) ? signed'(64'(vdist_q) << 16) : 64'sd0;
	assign ideal_w = 64'(owner_q[ax]) - (64'(prod_q) <<< 2) + vterm;
	assign acc_w   = (t1_q - prod_q) >>> 8;
	assign vel_w   = 64'(vel_q[ax]) + 64'(t1_q) + 64'(prod_q >>> 16);
	assign pos_w   = 64'(pos_q[ax]) + 64'(prod_q >>> 16);
	assign dvec_w  = 64'(owner_q[ax]) + (64'(prod_q) <<< 2) - 64'(pos_q[ax]);
	assign dmag_w  = dvec_w[63] ? -dvec_w : dvec_w;

	// largest magnitude
	always_comb begin
		mmax = mag_q[0];
		if (mag_q[1] > mmax) mmax = mag_q[1];
		if (mag_q[2] > mmax) mmax = mag_q[2];
	end

	// restoring divide step
	assign div_ge  = rem_q >= {1'b0, len_q};
	assign div_sub = div_ge ? rem_q - {1'b0, len_q} : rem_q;

	// square root unit, shared by damping and vector length
	assign sq_start = (cmd.op == OP_LOAD) || (cmd.op == OP_LEN_START);
	assign sq_num   = (cmd.op == OP_LOAD) ? {40'd0, kspr_q, 8'd0} : sum_q;

	sfc_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.num   (sq_num),
		.busy  (sq_busy),
		.root  (sq_root)
	);

	// camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				OP_SNAP: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= ideal_q[i];
						vel_q[i] <= '0;
					end
				end
				OP_VEL: vel_q[ax] <= sat32(vel_w);
				OP_POS: pos_q[ax] <= sat32(pos_w);
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				snap_q <= in_snap;
				for (int i = 0; i < 3; i++) begin
					owner_q[i] <= in_data[32*i +: 32];
					fwd_q[i]   <= in_data[96 + 16*i +: 16];
				end
				dt_q  <= in_data[159:144];
				sum_q <= '0;
			end
			OP_MUL_HF, OP_MUL_TF, OP_MUL_KD, OP_MUL_AH, OP_MUL_VD, OP_MUL_SQ: begin
				prod_q <= mul_a * mul_b;
			end
			OP_MUL_CV, OP_MUL_AL: begin
				t1_q   <= prod_q;
				prod_q <= mul_a * mul_b;
			end
			OP_IDEAL:     ideal_q[ax] <= sat32(ideal_w);
			OP_C_LATCH:   damp_q <= {sq_root[11:0], 1'b0};
			OP_ACC:       acc_q <= acc_w[47:0];
			OP_DIFF: begin
				mag_q[ax] <= dmag_w[35:0];
				neg_q[ax] <= dvec_w[63];
			end
			OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if (mmax[35:30] != 6'd0)
						mag_q[i] <= mag_q[i] >> 1;
					else
						mag_q[i] <= mag_q[i] << 1;
				end
			end
			OP_SUM:       sum_q <= sum_q + prod_q[63:0];
			OP_LEN_LATCH: len_q <= sq_root;
			OP_DIV_START: begin
				rem_q <= {3'd0, mag_q[ax][29:0]};
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= {div_sub[31:0], 1'b0};
				quo_q <= {quo_q[13:0], div_ge};
			end
			OP_LOOK: begin
				look_q[ax] <= neg_q[ax] ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
			end
			OP_LOOK_ZERO: begin
				for (int i = 0; i < 3; i++) look_q[i] <= '0;
			end
			OP_PUB: begin
				out_q <= {look_q[2], look_q[1], look_q[0], pos_q[2], pos_q[1], pos_q[0]};
			end
			default: ;
		endcase
	end

	// divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.op == OP_DIV_START) begin
			div_cnt_q <= DIV_STEPS;
		end else if (cmd.op == OP_DIV_STEP) begin
			div_cnt_q <= div_cnt_q - 4'd1;
		end
	end

	assign status.snap      = snap_q;
	assign status.sqrt_busy = sq_busy;
	assign status.vec_zero  = (mmax == 36'd0);
	assign status.norm_ok   = (mmax[35:30] == 6'd0) && mmax[29];
	assign status.div_done  = (div_cnt_q == 4'd0);

	assign out_data = out_q;

endmodule

// ===== src/sfc_ctrl.sv =====
// ---------------------------------------------------------------------------
// sfc_ctrl
// Sequencer: walks one item through the datapath and owns the handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfc_ctrl
	import sfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       out_valid_q;
	logic       last_axis;

	assign last_axis = (axis_q == AXIS_LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_PUB) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd.op   = OP_NONE;
		cmd.axis = axis_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					axis_d  = '0;
					state_d = S_HF_MUL;
				end
			end
			S_HF_MUL: begin
				cmd.op  = OP_MUL_HF;
				state_d = S_HF_SAT;
			end
			S_HF_SAT: begin
				cmd.op = OP_IDEAL;
				if (last_axis) begin
					axis_d  = '0;
					state_d = S_C_WAIT;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_HF_MUL;
				end
			end
			S_C_WAIT: begin
				if (!status.sqrt_busy) begin
					cmd.op  = OP_C_LATCH;
					state_d = status.snap ? S_SNAP : S_KD;
				end
			end
			S_SNAP: begin
				cmd.op  = OP_SNAP;
				state_d = S_TF;
			end
			S_KD: begin
				cmd.op  = OP_MUL_KD;
				state_d = S_CV;
			end
			S_CV: begin
				cmd.op  = OP_MUL_CV;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = S_AH;
			end
			S_AH: begin
				cmd.op  = OP_MUL_AH;
				state_d = S_AL;
			end
			S_AL: begin
				cmd.op  = OP_MUL_AL;
				state_d = S_VEL;
			end
			S_VEL: begin
				cmd.op  = OP_VEL;
				state_d = S_VD;
			end
			S_VD: begin
				cmd.op  = OP_MUL_VD;
				state_d = S_POS;
			end
			S_POS: begin
				cmd.op = OP_POS;
				if (last_axis) begin
					axis_d  = '0;
					state_d = S_TF;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_KD;
				end
			end
			S_TF: begin
				cmd.op  = OP_MUL_TF;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.op = OP_DIFF;
				if (last_axis) begin
					axis_d  = '0;
					state_d = S_ZCHK;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_TF;
				end
			end
			S_ZCHK: begin
				if (status.vec_zero) begin
					cmd.op  = OP_LOOK_ZERO;
					state_d = S_PUB;
				end else begin
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (status.norm_ok)
					state_d = S_SQ;
				else
					cmd.op = OP_NORM;
			end
			S_SQ: begin
				cmd.op  = OP_MUL_SQ;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.op = OP_SUM;
				if (last_axis) begin
					axis_d  = '0;
					state_d = S_LEN_START;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_SQ;
				end
			end
			S_LEN_START: begin
				cmd.op  = OP_LEN_START;
				state_d = S_LEN_WAIT;
			end
			S_LEN_WAIT: begin
				if (!status.sqrt_busy) begin
					cmd.op  = OP_LEN_LATCH;
					state_d = S_DIV_START;
				end
			end
			S_DIV_START: begin
				cmd.op  = OP_DIV_START;
				state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				if (!status.div_done) begin
					cmd.op = OP_DIV_STEP;
				end else begin
					cmd.op = OP_LOOK;
					if (last_axis) begin
						axis_d  = '0;
						state_d = S_PUB;
					end else begin
						axis_d  = axis_q + 2'd1;
						state_d = S_DIV_START;
					end
				end
			end
			S_PUB: begin
				if (!out_valid_q || m_tready) begin
					cmd.op  = OP_PUB;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	// checks
	`ASSERT_IMPL(a_pub_free, cmd.op == OP_PUB, !out_valid_q || m_tready, "result overwritten")
	`ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != S_IDLE, "item not taken up")
	`ASSERT_IMPL(a_len_idle, cmd.op == OP_LEN_START, !status.sqrt_busy, "root unit still busy")

endmodule
